>>> rtl/pec_pkg.sv
// Shared widths and Q12 constants for the power easing curve block.
`default_nettype none

package pec_pkg;

	localparam int TIME_W  = 16;
	localparam int POWER_W = 4;
	localparam int Q_W     = 13;
	localparam int Q_SHIFT = 12;

	localparam logic [Q_W-1:0] Q_ONE  = Q_W'('h1000);
	localparam logic [Q_W-1:0] Q_HALF = Q_W'('h800);

	// quotient of the ratio divide; the second half of ease-in-out can reach 2 * Q_ONE
	localparam int QUO_W = Q_W + 1;

	// digit-serial multiplier geometry
	localparam int DIGIT_W = 8;
	localparam int NDIG    = (Q_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MUL_W   = NDIG * DIGIT_W;
	localparam int ACC_W   = Q_W + MUL_W;

endpackage

`default_nettype wire

>>> rtl/pec_in_if.sv
// Input channel: one curve request word per handshake.
`default_nettype none

interface pec_in_if;

	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [pec_pkg::TIME_W-1:0]        elapsed;
	logic [pec_pkg::TIME_W-1:0]        duration;
	logic [pec_pkg::POWER_W-1:0]       power;

	modport source (output valid, mode, elapsed, duration, power, input ready);
	modport sink   (input valid, mode, elapsed, duration, power, output ready);

endinterface

`default_nettype wire

>>> rtl/pec_out_if.sv
// Output channel: one eased progress word per handshake.
`default_nettype none

interface pec_out_if;

	logic                      valid;
	logic                      ready;
	logic [pec_pkg::Q_W-1:0]   progress;
	logic                      range_error;

	modport source (output valid, progress, range_error, input ready);
	modport sink   (input valid, progress, range_error, output ready);

endinterface

`default_nettype wire

>>> rtl/pec_div.sv
// Bit-serial restoring divider: quotient of (num << 12) / den, one bit per cycle.
`default_nettype none

module pec_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pec_pkg::TIME_W-1:0]    num,
	input  wire logic [pec_pkg::TIME_W-1:0]    den,
	output logic                               done,
	output logic [pec_pkg::QUO_W-1:0]          quo
);

	localparam int PRE   = pec_pkg::QUO_W - pec_pkg::Q_SHIFT;
	localparam int CNT_W = $clog2(pec_pkg::QUO_W + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [pec_pkg::TIME_W-1:0]    rem_q;
	logic [pec_pkg::TIME_W-1:0]    den_q;
	logic [pec_pkg::QUO_W-1:0]     low_q;
	logic [pec_pkg::QUO_W-1:0]     quo_q;

	logic [pec_pkg::TIME_W:0]      trial;
	logic [pec_pkg::TIME_W:0]      diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, low_q[pec_pkg::QUO_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			low_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pec_pkg::QUO_W);
				rem_q  <= num >> PRE;
				den_q  <= den;
				low_q  <= {num[PRE-1:0], {pec_pkg::Q_SHIFT{1'b0}}};
			end else if (busy_q) begin
				rem_q <= ge ? diff[pec_pkg::TIME_W-1:0] : trial[pec_pkg::TIME_W-1:0];
				quo_q <= {quo_q[pec_pkg::QUO_W-2:0], ge};
				low_q <= low_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> rtl/pec_mul.sv
// Digit-serial Q12 multiplier: (a * b) >> 12, one 8-bit digit of b per cycle.
`default_nettype none

module pec_mul (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pec_pkg::Q_W-1:0]    a,
	input  wire logic [pec_pkg::Q_W-1:0]    b,
	output logic                            done,
	output logic [pec_pkg::Q_W-1:0]         prod
);

	localparam int PP_W  = pec_pkg::Q_W + pec_pkg::DIGIT_W;
	localparam int CNT_W = (pec_pkg::NDIG > 1) ? $clog2(pec_pkg::NDIG) : 1;

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [pec_pkg::Q_W-1:0]       a_q;
	logic [pec_pkg::MUL_W-1:0]     b_sh_q;
	logic [pec_pkg::ACC_W-1:0]     acc_q;

	logic [pec_pkg::Q_W-1:0]       a_op;
	logic [pec_pkg::MUL_W-1:0]     b_pad;
	logic [pec_pkg::DIGIT_W-1:0]   dig;
	logic [pec_pkg::ACC_W-1:0]     acc_in;
	logic [PP_W-1:0]               pp;
	logic [pec_pkg::ACC_W-1:0]     acc_nx;

	always_comb begin
		b_pad  = pec_pkg::MUL_W'(b);
		a_op   = start ? a : a_q;
		dig    = start ? b_pad[pec_pkg::DIGIT_W-1:0] : b_sh_q[pec_pkg::DIGIT_W-1:0];
		acc_in = start ? '0 : acc_q;
		pp     = PP_W'(a_op) * PP_W'(dig);
		acc_nx = (acc_in >> pec_pkg::DIGIT_W)
			+ (pec_pkg::ACC_W'(pp) << (pec_pkg::MUL_W - pec_pkg::DIGIT_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_sh_q <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_sh_q <= b_pad >> pec_pkg::DIGIT_W;
				acc_q  <= acc_nx;
				if (pec_pkg::NDIG == 1) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(pec_pkg::NDIG - 1);
				end
			end else if (busy_q) begin
				acc_q  <= acc_nx;
				b_sh_q <= b_sh_q >> pec_pkg::DIGIT_W;
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q[pec_pkg::Q_SHIFT +: pec_pkg::Q_W];

endmodule

`default_nettype wire

>>> rtl/power_easing_curve_q12.sv
// Top level of the power easing curve: request decode, sequencer and result register.
`default_nettype none

// Evaluates polynomial easing in Q12 (4096 = complete): linear when power is 0,
// ease-out in mode 0, ease-in-out in mode 1, with exponent power + 1. One request
// is worked at a time. The ratio divide yields one quotient bit per cycle, and
// each of the power Q12 multiplies takes one 8-bit digit of the base per cycle.
// Requests that set range_error (zero divisor or elapsed beyond duration) return
// 4096. The result register lets the next request be accepted while a finished
// result still waits on the output.
module power_easing_curve_q12 #(
	parameter int MAX_POWER  = 15,
	parameter int TIME_WIDTH = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pec_in_if.sink      sample,
	pec_out_if.source   result
);

	localparam int TW = (TIME_WIDTH < pec_pkg::TIME_W) ? TIME_WIDTH : pec_pkg::TIME_W;
	localparam logic [pec_pkg::TIME_W-1:0] TIME_MASK =
		pec_pkg::TIME_W'((64'd1 << TW) - 64'd1);
	localparam logic [pec_pkg::POWER_W-1:0] POW_CAP =
		(MAX_POWER >= (1 << pec_pkg::POWER_W) - 1) ? '1 : pec_pkg::POWER_W'(MAX_POWER);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		C_LINEAR,
		C_OUT,
		C_IN_LO,
		C_IN_HI
	} curve_t;

	state_t                          state_q;
	curve_t                          curve_q;
	logic [pec_pkg::POWER_W-1:0]     steps_q;
	logic [pec_pkg::Q_W-1:0]         base_q;
	logic [pec_pkg::Q_W-1:0]         pend_prog_q;
	logic                            pend_err_q;
	logic                            out_valid_q;
	logic [pec_pkg::Q_W-1:0]         progress_q;
	logic                            range_error_q;

	logic                            accept;
	logic                            load_out;
	logic [pec_pkg::TIME_W-1:0]      e_m;
	logic [pec_pkg::TIME_W-1:0]      d_m;
	logic [pec_pkg::TIME_W-1:0]      half;
	logic [pec_pkg::TIME_W-1:0]      den;
	logic [pec_pkg::TIME_W-1:0]      num;
	logic [pec_pkg::POWER_W-1:0]     pw;
	logic                            split;
	logic                            upper;
	logic                            err;
	curve_t                          curve_s;

	logic                            div_done;
	logic [pec_pkg::QUO_W-1:0]       div_quo;
	logic [pec_pkg::QUO_W-1:0]       fold_s;
	logic [pec_pkg::Q_W-1:0]         base_s;

	logic                            mul_start;
	logic [pec_pkg::Q_W-1:0]         mul_a;
	logic [pec_pkg::Q_W-1:0]         mul_b;
	logic                            mul_done;
	logic [pec_pkg::Q_W-1:0]         mul_prod;
	logic [pec_pkg::Q_W-1:0]         rest;
	logic [pec_pkg::Q_W-1:0]         fin_s;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign load_out     = (state_q == S_OUT) && (!out_valid_q || result.ready);

	always_comb begin
		e_m   = sample.elapsed & TIME_MASK;
		d_m   = sample.duration & TIME_MASK;
		pw    = (sample.power > POW_CAP) ? POW_CAP : sample.power;
		half  = d_m >> 1;
		split = sample.mode && (pw != '0);
		den   = split ? half : d_m;
		err   = (e_m > d_m) || (den == '0);
		upper = split && (e_m >= half);
		num   = upper ? e_m - half : e_m;
		if (pw == '0) begin
			curve_s = C_LINEAR;
		end else if (!sample.mode) begin
			curve_s = C_OUT;
		end else if (upper) begin
			curve_s = C_IN_HI;
		end else begin
			curve_s = C_IN_LO;
		end
	end

	pec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !err),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		fold_s = (div_quo > pec_pkg::QUO_W'(pec_pkg::Q_ONE))
			? div_quo - pec_pkg::QUO_W'(pec_pkg::Q_ONE)
			: pec_pkg::QUO_W'(pec_pkg::Q_ONE) - div_quo;
		base_s = (curve_q == C_IN_LO) ? div_quo[pec_pkg::Q_W-1:0] : fold_s[pec_pkg::Q_W-1:0];
	end

	always_comb begin
		mul_start = ((state_q == S_DIV) && div_done && (curve_q != C_LINEAR))
			|| ((state_q == S_MUL) && mul_done && (steps_q != pec_pkg::POWER_W'(1)));
		mul_a     = (state_q == S_DIV) ? base_s : mul_prod;
		mul_b     = (state_q == S_DIV) ? base_s : base_q;
	end

	pec_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_comb begin
		rest = pec_pkg::Q_ONE - mul_prod;
		unique case (curve_q)
			C_OUT:   fin_s = rest;
			C_IN_LO: fin_s = mul_prod >> 1;
			C_IN_HI: fin_s = (rest >> 1) + pec_pkg::Q_HALF;
			default: fin_s = mul_prod;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			curve_q       <= C_LINEAR;
			steps_q       <= '0;
			base_q        <= '0;
			pend_prog_q   <= '0;
			pend_err_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			progress_q    <= '0;
			range_error_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						curve_q <= curve_s;
						steps_q <= pw;
						if (err) begin
							pend_prog_q <= pec_pkg::Q_ONE;
							pend_err_q  <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							pend_err_q <= 1'b0;
							state_q    <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (curve_q == C_LINEAR) begin
							pend_prog_q <= div_quo[pec_pkg::Q_W-1:0];
							state_q     <= S_OUT;
						end else begin
							base_q  <= base_s;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						if (steps_q == pec_pkg::POWER_W'(1)) begin
							pend_prog_q <= fin_s;
							state_q     <= S_OUT;
						end else begin
							steps_q <= steps_q - pec_pkg::POWER_W'(1);
						end
					end
				end
				S_OUT: begin
					if (load_out) begin
						progress_q    <= pend_prog_q;
						range_error_q <= pend_err_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.progress    = progress_q;
	assign result.range_error = range_error_q;

	a_progress_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> progress_q <= pec_pkg::Q_ONE)
		else $error("progress above Q12 one");

	a_error_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && range_error_q |-> progress_q == pec_pkg::Q_ONE)
		else $error("range error without full progress");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide phase");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == S_MUL)
		else $error("multiplier finished outside power phase");

	a_mul_operands: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> (base_q <= pec_pkg::Q_ONE) && (steps_q != '0))
		else $error("power phase with bad base or step count");

endmodule

`default_nettype wire

>>> tb/sv/power_easing_curve_q12_test.sv
// Self-checking testbench for power_easing_curve_q12: directed and random easing requests.
`timescale 1ns / 1ps

typedef enum logic {
	EASE_OUT    = 1'b0,
	EASE_IN_OUT = 1'b1
} ease_mode_e;

typedef struct packed {
	ease_mode_e                       mode;
	logic [pec_pkg::TIME_W-1:0]       elapsed;
	logic [pec_pkg::TIME_W-1:0]       duration;
	logic [pec_pkg::POWER_W-1:0]      power;
} curve_req_t;

typedef struct {
	logic [pec_pkg::Q_W-1:0] progress;
	logic                    range_error;
} curve_result_t;

class easing_scoreboard;
	curve_result_t pending[$];
	int            errors;

	function new();
		errors = 0;
	endfunction

	static function logic [63:0] q12_power(logic [63:0] base, int unsigned steps);
		logic [63:0] acc;
		acc = base;
		for (int unsigned k = 0; k < steps; k++)
			acc = (acc * base) >> pec_pkg::Q_SHIFT;
		return acc;
	endfunction

	static function logic [63:0] distance_to_one(logic [63:0] ratio);
		logic [63:0] one;
		one = 64'(pec_pkg::Q_ONE);
		return (ratio > one) ? ratio - one : one - ratio;
	endfunction

	static function curve_result_t eased_progress(curve_req_t w);
		curve_result_t res;
		logic [63:0]   e, dur, half, d, r, prog, one;
		logic          err;
		one  = 64'(pec_pkg::Q_ONE);
		e    = 64'(w.elapsed);
		dur  = 64'(w.duration);
		err  = 1'b0;
		prog = one;
		if (e > dur) begin
			err = 1'b1;
		end else if (w.power == 0) begin
			if (dur == 0) err = 1'b1;
			else prog = (e << pec_pkg::Q_SHIFT) / dur;
		end else if (w.mode == EASE_OUT) begin
			if (dur == 0) begin
				err = 1'b1;
			end else begin
				d    = distance_to_one((e << pec_pkg::Q_SHIFT) / dur);
				prog = one - q12_power(d, w.power);
			end
		end else begin
			half = dur >> 1;
			if (half == 0) begin
				err = 1'b1;
			end else if (e < half) begin
				prog = q12_power((e << pec_pkg::Q_SHIFT) / half, w.power) >> 1;
			end else begin
				d    = distance_to_one(((e - half) << pec_pkg::Q_SHIFT) / half);
				r    = q12_power(d, w.power);
				prog = ((one - r) >> 1) + 64'(pec_pkg::Q_HALF);
			end
		end
		res.progress    = prog[pec_pkg::Q_W-1:0];
		res.range_error = err;
		return res;
	endfunction

	function void note_request(curve_req_t w);
		pending.push_back(eased_progress(w));
	endfunction

	function void check_result(logic [pec_pkg::Q_W-1:0] progress, logic range_error);
		curve_result_t want;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected word: progress %0d range_error %0b",
				$time, progress, range_error);
			return;
		end
		want = pending.pop_front();
		if (progress !== want.progress) begin
			errors++;
			$display("%0t: progress expected %0d actual %0d",
				$time, want.progress, progress);
		end
		if (range_error !== want.range_error) begin
			errors++;
			$display("%0t: range_error expected %0b actual %0b",
				$time, want.range_error, range_error);
		end
	endfunction
endclass

module power_easing_curve_q12_test;

	localparam int CYCLE_LIMIT = 400000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             steady;
	int               cycles = 0;
	easing_scoreboard sb;

	pec_in_if  in_if ();
	pec_out_if out_if ();

	power_easing_curve_q12 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (in_if),
		.result (out_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_if.valid && out_if.ready)
			sb.check_result(out_if.progress, out_if.range_error);
		out_if.ready <= arst_n && (steady || $urandom_range(99) >= 11);
	end

	function automatic curve_req_t make_req(ease_mode_e mode, int e, int d, int p);
		curve_req_t w;
		w.mode     = mode;
		w.elapsed  = pec_pkg::TIME_W'(e);
		w.duration = pec_pkg::TIME_W'(d);
		w.power    = pec_pkg::POWER_W'(p);
		return w;
	endfunction

	function automatic curve_req_t random_req();
		curve_req_t  w;
		int unsigned pick, dur;
		w.mode  = ease_mode_e'($urandom_range(1, 0));
		w.power = pec_pkg::POWER_W'($urandom_range(15, 0));
		pick = $urandom_range(7, 0);
		if (pick == 0) dur = $urandom_range(5, 0);
		else if (pick < 4) dur = $urandom_range(4095, 2);
		else dur = $urandom_range(65535, 0);
		w.duration = pec_pkg::TIME_W'(dur);
		pick = $urandom_range(19, 0);
		if (pick == 0) w.elapsed = w.duration;
		else if (pick == 1) w.elapsed = w.duration >> 1;
		else if (pick == 2 && dur < 65535)
			w.elapsed = pec_pkg::TIME_W'($urandom_range(65535, dur + 1));
		else if (pick == 3) w.elapsed = pec_pkg::TIME_W'($urandom_range(65535, 0));
		else w.elapsed = pec_pkg::TIME_W'($urandom_range(dur, 0));
		return w;
	endfunction

	task automatic send_word(curve_req_t w);
		if (!steady && $urandom_range(99) < 11) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_if.valid    <= 1'b1;
		in_if.mode     <= w.mode;
		in_if.elapsed  <= w.elapsed;
		in_if.duration <= w.duration;
		in_if.power    <= w.power;
		do @(posedge clk); while (!in_if.ready);
		sb.note_request(w);
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	initial begin
		curve_req_t directed[$];
		sb = new();
		arst_n         = 1'b0;
		steady         = 1'b0;
		in_if.valid    = 1'b0;
		in_if.mode     = EASE_OUT;
		in_if.elapsed  = '0;
		in_if.duration = '0;
		in_if.power    = '0;

		directed.push_back(make_req(EASE_OUT, 0, 100, 0));
		directed.push_back(make_req(EASE_OUT, 100, 100, 0));
		directed.push_back(make_req(EASE_IN_OUT, 65535, 65535, 0));
		directed.push_back(make_req(EASE_OUT, 1, 65535, 0));
		directed.push_back(make_req(EASE_OUT, 0, 1000, 1));
		directed.push_back(make_req(EASE_OUT, 500, 1000, 15));
		directed.push_back(make_req(EASE_OUT, 1000, 1000, 15));
		directed.push_back(make_req(EASE_IN_OUT, 0, 1000, 3));
		directed.push_back(make_req(EASE_IN_OUT, 499, 1000, 3));
		directed.push_back(make_req(EASE_IN_OUT, 500, 1000, 3));
		directed.push_back(make_req(EASE_IN_OUT, 1000, 1000, 15));
		directed.push_back(make_req(EASE_IN_OUT, 7, 7, 2));
		directed.push_back(make_req(EASE_IN_OUT, 3, 3, 1));
		directed.push_back(make_req(EASE_IN_OUT, 2, 3, 1));
		directed.push_back(make_req(EASE_OUT, 0, 0, 0));
		directed.push_back(make_req(EASE_OUT, 0, 0, 5));
		directed.push_back(make_req(EASE_IN_OUT, 0, 1, 4));
		directed.push_back(make_req(EASE_IN_OUT, 0, 0, 15));
		directed.push_back(make_req(EASE_OUT, 101, 100, 7));
		directed.push_back(make_req(EASE_OUT, 65535, 0, 0));
		directed.push_back(make_req(EASE_IN_OUT, 65535, 65534, 15));
		directed.push_back(make_req(EASE_OUT, 65535, 65535, 15));
		directed.push_back(make_req(EASE_IN_OUT, 32767, 65535, 15));
		directed.push_back(make_req(EASE_IN_OUT, 0, 65535, 1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_word(directed[i]);
		drain();

		for (int i = 0; i < 550; i++) begin
			steady <= (i >= 200 && i < 300);
			if (i == 350) drain();
			send_word(random_req());
		end
		drain();
		repeat (60) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> power_easing_curve_q12.f
rtl/pec_pkg.sv
rtl/pec_in_if.sv
rtl/pec_out_if.sv
rtl/pec_div.sv
rtl/pec_mul.sv
rtl/power_easing_curve_q12.sv
tb/sv/power_easing_curve_q12_test.sv
